@@ rtl/core/ecfb_pkg.sv @@
// ----------------------------------------------------------------------------
// ecfb_pkg
// Types, wire constants and byte functions shared by the escaped frame builder
// ----------------------------------------------------------------------------
`default_nettype none

package ecfb_pkg;

	localparam logic [7:0] FLAG_OPEN  = 8'hDF;
	localparam logic [7:0] FLAG_CLOSE = 8'hFD;
	localparam logic [7:0] ESC_OPEN   = 8'hDE;
	localparam logic [7:0] ESC_CLOSE  = 8'hFC;
	localparam logic [7:0] ESC_ONE    = 8'h01;
	localparam logic [7:0] ESC_ZERO   = 8'h00;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	localparam logic KIND_START   = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_STRAY   = 2'd1;
	localparam logic [1:0] STATUS_ABANDON = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [7:0]  sub_command;
		logic [15:0] payload_length;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       frame_end;
		logic [1:0] status;
	} res_t;

	// reflected crc-16, one byte per call
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic is_special(input logic [7:0] b);
		return (b == FLAG_OPEN) || (b == ESC_OPEN) || (b == FLAG_CLOSE) || (b == ESC_CLOSE);
	endfunction

	function automatic logic [7:0] esc_prefix(input logic [7:0] b);
		return ((b == FLAG_OPEN) || (b == ESC_OPEN)) ? ESC_OPEN : ESC_CLOSE;
	endfunction

	function automatic logic [7:0] esc_suffix(input logic [7:0] b);
		return ((b == FLAG_OPEN) || (b == FLAG_CLOSE)) ? ESC_ONE : ESC_ZERO;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/escaped_crc_frame_builder.sv @@
// ----------------------------------------------------------------------------
// escaped_crc_frame_builder
// Byte-stuffed transmit frame builder with crc-16/modbus trailer
// ----------------------------------------------------------------------------
// path: the input item is registered, then each wire byte passes through the two-entry output buffer
// throughput: one wire byte per cycle from the sequencer while the output buffer has
//   room; an item causes 1-2 results for a payload byte, 7-11 for a start, and
//   3-5 more where the crc trailer and closing flag follow
// reset: arst_n clears the open frame, crc to 0xffff and top_command to 0
`default_nettype none

module escaped_crc_frame_builder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // sub_command, payload_length, data_byte
	input  wire logic        s_axis_tuser,  // kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // out_byte
	output logic             m_axis_tlast,  // run_last
	output logic [3:0]       m_axis_tuser,  // byte_valid, frame_end, status
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);

	ecfb_pkg::item_t item_s1;
	logic            valid_s1;
	logic [7:0]      top_command_q;
	ecfb_pkg::res_t  seq_res, out_res;
	logic            emit, item_done, buf_ready;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !valid_s1 || item_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_command_q <= 8'h00;
		end else if (cfg_valid && cfg_ready) begin
			top_command_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.kind           <= s_axis_tuser;
			item_s1.sub_command    <= s_axis_tdata[7:0];
			item_s1.payload_length <= s_axis_tdata[23:8];
			item_s1.data_byte      <= s_axis_tdata[31:24];
		end
	end

	ecfb_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_s1),
		.item_valid  (valid_s1),
		.top_command (top_command_q),
		.emit_ready  (buf_ready),
		.res         (seq_res),
		.emit        (emit),
		.item_done   (item_done)
	);

	ecfb_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (emit),
		.in_ready  (buf_ready),
		.in_res    (seq_res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = out_res.out_byte;
	assign m_axis_tlast = out_res.run_last;
	assign m_axis_tuser = {out_res.status, out_res.frame_end, out_res.byte_valid};

endmodule

`default_nettype wire

@@ rtl/core/ecfb_seq.sv @@
// ----------------------------------------------------------------------------
// ecfb_seq
// Frame sequencer: while the output buffer has room, turns the held item into wire bytes, one per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ecfb_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ecfb_pkg::item_t  item,
	input  wire logic             item_valid,
	input  wire logic [7:0]       top_command,
	input  wire logic             emit_ready,
	output ecfb_pkg::res_t        res,
	output logic                  emit,
	output logic                  item_done
);

	typedef enum logic [3:0] {
		ST_FLAG, ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5,
		ST_DATA, ST_CRC_HI, ST_CRC_LO, ST_CLOSE, ST_STRAY
	} step_t;

	step_t       step_q, init_step, cur_step, next_step;
	logic        fresh_q, esc_q, frame_open_q;
	logic [15:0] crc_q, bytes_left_q;
	logic [1:0]  status_q, init_status, cur_status;
	logic [7:0]  unit_byte, wire_byte;
	logic        counted, escable, need_esc, unit_done, item_end;

	always_comb begin
		if (item.kind == ecfb_pkg::KIND_START) begin
			init_step   = ST_FLAG;
			init_status = frame_open_q ? ecfb_pkg::STATUS_ABANDON : ecfb_pkg::STATUS_OK;
		end else if (frame_open_q) begin
			init_step   = ST_DATA;
			init_status = ecfb_pkg::STATUS_OK;
		end else begin
			init_step   = ST_STRAY;
			init_status = ecfb_pkg::STATUS_STRAY;
		end
		cur_step   = fresh_q ? init_step : step_q;
		cur_status = fresh_q ? init_status : status_q;
	end

	always_comb begin
		unit_byte = ecfb_pkg::ESC_ZERO;
		counted   = 1'b0;
		escable   = 1'b0;
		next_step = ST_FLAG;
		item_end  = 1'b0;
		case (cur_step)
			ST_FLAG: begin
				unit_byte = ecfb_pkg::FLAG_OPEN;
				next_step = ST_H0;
			end
			ST_H0: begin
				unit_byte = item.payload_length[15:8];
				counted   = 1'b1;
				next_step = ST_H1;
			end
			ST_H1: begin
				unit_byte = item.payload_length[7:0];
				counted   = 1'b1;
				next_step = ST_H2;
			end
			ST_H2: begin
				counted   = 1'b1;
				next_step = ST_H3;
			end
			ST_H3: begin
				counted   = 1'b1;
				next_step = ST_H4;
			end
			ST_H4: begin
				unit_byte = top_command;
				counted   = 1'b1;
				next_step = ST_H5;
			end
			ST_H5: begin
				unit_byte = item.sub_command;
				counted   = 1'b1;
				next_step = ST_CRC_HI;
				item_end  = (bytes_left_q != 16'd0);
			end
			ST_DATA: begin
				unit_byte = item.data_byte;
				counted   = 1'b1;
				next_step = ST_CRC_HI;
				item_end  = (bytes_left_q != 16'd1);
			end
			ST_CRC_HI: begin
				unit_byte = crc_q[15:8];
				escable   = 1'b1;
				next_step = ST_CRC_LO;
			end
			ST_CRC_LO: begin
				unit_byte = crc_q[7:0];
				escable   = 1'b1;
				next_step = ST_CLOSE;
			end
			ST_CLOSE: begin
				unit_byte = ecfb_pkg::FLAG_CLOSE;
				item_end  = 1'b1;
			end
			ST_STRAY: begin
				item_end  = 1'b1;
			end
			default: begin
				item_end  = 1'b1;
			end
		endcase
	end

	always_comb begin
		need_esc  = (counted || escable) && ecfb_pkg::is_special(unit_byte);
		unit_done = !need_esc || esc_q;
		if (esc_q) begin
			wire_byte = ecfb_pkg::esc_suffix(unit_byte);
		end else if (need_esc) begin
			wire_byte = ecfb_pkg::esc_prefix(unit_byte);
		end else begin
			wire_byte = unit_byte;
		end
		emit           = item_valid && emit_ready;
		res.out_byte   = wire_byte;
		res.byte_valid = (cur_step != ST_STRAY);
		res.run_last   = unit_done && item_end;
		res.frame_end  = (cur_step == ST_CLOSE);
		res.status     = cur_status;
		item_done      = emit && res.run_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= ST_FLAG;
			fresh_q      <= 1'b1;
			esc_q        <= 1'b0;
			frame_open_q <= 1'b0;
			crc_q        <= ecfb_pkg::CRC_INIT;
			bytes_left_q <= 16'd0;
			status_q     <= ecfb_pkg::STATUS_OK;
		end else if (emit) begin
			fresh_q <= item_done;
			esc_q   <= !unit_done;
			// hold the step across the escape suffix, also on an item's first byte
			if (unit_done) begin
				step_q <= next_step;
			end else begin
				step_q <= cur_step;
			end
			if (fresh_q) begin
				status_q <= init_status;
			end
			if (cur_step == ST_FLAG) begin
				crc_q        <= ecfb_pkg::CRC_INIT;
				bytes_left_q <= item.payload_length;
				frame_open_q <= 1'b1;
			end
			// crc takes the unescaped byte on its first wire byte
			if (counted && !esc_q) begin
				crc_q <= ecfb_pkg::crc_update(crc_q, unit_byte);
			end
			if (cur_step == ST_DATA && unit_done) begin
				bytes_left_q <= bytes_left_q - 16'd1;
			end
			if (cur_step == ST_CLOSE) begin
				frame_open_q <= 1'b0;
				bytes_left_q <= 16'd0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ecfb_out_buf.sv @@
// ----------------------------------------------------------------------------
// ecfb_out_buf
// Two-entry result buffer between the sequencer and the output stream
// ----------------------------------------------------------------------------
`default_nettype none

module ecfb_out_buf (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire ecfb_pkg::res_t  in_res,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output ecfb_pkg::res_t       out_res
);

	ecfb_pkg::res_t entry_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     count_q;
	logic           push, pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_res   = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire
